// File: rtl/core/olist_pkg.sv
package olist_pkg;

  localparam int OL_CAPACITY   = 16;
  localparam int OL_ACT_W      = 3;
  localparam int OL_VAL_W      = 32;
  localparam int OL_POS_W      = 5;
  localparam int OL_IN_TDATA_W  = 40;
  localparam int OL_OUT_TDATA_W = 48;

  typedef enum logic [OL_ACT_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5,
    OP_FIND       = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    op_t                        op;
    logic signed [OL_VAL_W-1:0] value;
    logic [OL_POS_W-1:0]        position;
  } cmd_t;

endpackage

// File: rtl/core/olist_front.sv
module olist_front
  import olist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [OL_IN_TDATA_W-1:0] in_tdata,
  output logic                     q_valid,
  input  logic                     q_ready,
  output cmd_t                     q_cmd
);

  cmd_t       mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.value    = in_tdata[OL_ACT_W +: OL_VAL_W];
    cmd_in.position = in_tdata[OL_ACT_W+OL_VAL_W +: OL_POS_W];
    unique case (in_tdata[OL_ACT_W-1:0])
      3'd0:    cmd_in.op = OP_PUSH_FRONT;
      3'd1:    cmd_in.op = OP_PUSH_BACK;
      3'd2:    cmd_in.op = OP_POP_FRONT;
      3'd3:    cmd_in.op = OP_POP_BACK;
      3'd4:    cmd_in.op = OP_REMOVE;
      3'd5:    cmd_in.op = OP_READ;
      3'd6:    cmd_in.op = OP_FIND;
      default: cmd_in.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = mem_r[rd_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= cmd_in;
    end
  end

endmodule

// File: rtl/core/olist_back.sv
module olist_back
  import olist_pkg::*;
#(
  parameter int CAPACITY = OL_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  cmd_t                      q_cmd,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OL_OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > OL_POS_W) ? CW : OL_POS_W;

  logic signed [OL_VAL_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  cmd_t                       cmd_r;
  logic [CAPACITY-1:0]        match_r;
  state_t                     state_r;
  state_t                     state_nxt;

  logic                       exec_go;
  logic                       capture;
  logic [CAPACITY-1:0]        first_hit;
  logic [CAPACITY-1:0]        after_mask;
  logic [CAPACITY-1:0]        left_mask;
  logic                       hit;
  logic [IW-1:0]              hit_idx;
  logic                       full;
  logic                       empty;
  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext;
  logic [PW-1:0]              cnt_nxt_ext;
  logic [PW-1:0]              fp_ext;
  logic                       pos_ok;
  logic [IW-1:0]              rd_idx;
  logic                       sh_right;
  logic                       wr_tail;
  logic                       ok;
  logic signed [OL_VAL_W-1:0] rd_val;
  logic [OL_POS_W-1:0]        fp;

  logic                       out_valid_r;
  logic                       out_ok_r;
  logic signed [OL_VAL_W-1:0] out_rd_r;
  logic [OL_POS_W-1:0]        out_fp_r;
  logic [OL_POS_W-1:0]        out_cnt_r;
  logic                       out_empty_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    exec_go = 1'b0;
    unique case (state_r)
      ST_IDLE: q_ready = 1'b1;
      ST_EXEC: exec_go = !out_valid_r || out_tready;
      default: begin
        q_ready = 1'b0;
        exec_go = 1'b0;
      end
    endcase
  end

  assign capture = q_valid && q_ready;

  // isolate first match; mask covers it and every cell above
  assign first_hit  = match_r & (~match_r + CAPACITY'(1));
  assign after_mask = match_r | (~match_r + CAPACITY'(1));
  assign hit        = |match_r;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign full        = (count_r == CW'(CAPACITY));
  assign empty       = (count_r == '0);
  assign pos_ext     = PW'(cmd_r.position);
  assign cnt_ext     = PW'(count_r);
  assign cnt_nxt_ext = PW'(count_nxt);
  assign pos_ok      = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign rd_idx      = IW'(pos_ext - PW'(1));
  assign fp_ext      = PW'(hit_idx) + PW'(1);

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    sh_right  = 1'b0;
    wr_tail   = 1'b0;
    left_mask = '0;
    rd_val    = '0;
    fp        = '0;
    unique case (cmd_r.op)
      OP_PUSH_FRONT: begin
        ok        = !full;
        sh_right  = !full;
        count_nxt = full ? count_r : count_r + CW'(1);
      end
      OP_PUSH_BACK: begin
        ok        = !full;
        wr_tail   = !full;
        count_nxt = full ? count_r : count_r + CW'(1);
      end
      OP_POP_FRONT: begin
        ok        = !empty;
        left_mask = empty ? '0 : '1;
        count_nxt = empty ? count_r : count_r - CW'(1);
      end
      OP_POP_BACK: begin
        ok        = !empty;
        count_nxt = empty ? count_r : count_r - CW'(1);
      end
      OP_REMOVE: begin
        ok        = hit;
        left_mask = after_mask;
        count_nxt = hit ? count_r - CW'(1) : count_r;
      end
      OP_READ: begin
        ok     = pos_ok;
        rd_val = pos_ok ? entries_r[rd_idx] : '0;
      end
      OP_FIND: begin
        ok = hit;
        fp = hit ? fp_ext[OL_POS_W-1:0] : '0;
      end
      OP_NOP: ok = 1'b0;
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cmd_r <= q_cmd;
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= (entries_r[i] == q_cmd.value) && (CW'(i) < count_r);
      end
    end
    if (exec_go) begin
      out_ok_r    <= ok;
      out_rd_r    <= rd_val;
      out_fp_r    <= fp;
      out_cnt_r   <= cnt_nxt_ext[OL_POS_W-1:0];
      out_empty_r <= (count_nxt == '0);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [OL_VAL_W-1:0] from_left;
    logic signed [OL_VAL_W-1:0] from_right;
    logic                       can_left;
    if (g == 0) begin : g_head
      assign from_left = cmd_r.value;
    end else begin : g_body
      assign from_left = entries_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign from_right = entries_r[g];
      assign can_left   = 1'b0;
    end else begin : g_mid
      assign from_right = entries_r[g+1];
      assign can_left   = 1'b1;
    end
    always_ff @(posedge clk) begin
      if (exec_go) begin
        if (sh_right) begin
          entries_r[g] <= from_left;
        end else if (left_mask[g] && can_left) begin
          entries_r[g] <= from_right;
        end else if (wr_tail && (CW'(g) == count_r)) begin
          entries_r[g] <= cmd_r.value;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_empty_r, out_cnt_r, out_fp_r, out_rd_r, out_ok_r};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_exec_loads: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("executed item not presented");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_go |=> $stable(count_r))
    else $error("count changed without an item");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (state_r == ST_EXEC))
    else $error("captured item not executed");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(first_hit))
    else $error("more than one first match");
`endif

endmodule

// File: rtl/core/ordered_list_engine_top.sv
// Bounded ordered list of signed 32-bit entries, front at position 1.
// Input channel in_*: one item per request (push front/back, pop front/back,
// remove value, read position, find value). Output channel out_*: exactly one
// result item per request, in request order, carrying ok, the value read,
// the position found, the entry count after the request and an empty flag.
// From input acceptance to out_tvalid, an item passes the queue write, the
// compare stage and the execute stage when the back end is idle and the
// output is free. The back end takes one item at a time: it compares all
// entries against the value in the compare stage and shifts the whole entry
// row in the execute stage before it takes the next item. A two-entry queue
// separates the input side from the back end, so inputs are taken while a result waits on out_tready.
// Reset (rst_n low, synchronous): list empty, queue empty, no result pending.
// Entry storage is not cleared; only entries below the count are ever read.
// When out_tready is low the result is held and the back end stalls; the
// queue then fills and in_tready drops.
module ordered_list_engine_top
  import olist_pkg::*;
#(
  parameter int CAPACITY = OL_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // action[2:0], value[34:3], position[39:35]
  input  logic [OL_IN_TDATA_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // ok[0], read_value[32:1], found_position[37:33], entry_count[42:38],
  // is_empty[43], zero[47:44]
  output logic [OL_OUT_TDATA_W-1:0] out_tdata
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  olist_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  olist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: verif/tb_ordered_list_engine_top.sv
`timescale 1ns / 100ps

module tb_ordered_list_engine_top;
  import olist_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                        ok;
    logic signed [OL_VAL_W-1:0]  read_value;
    logic [OL_POS_W-1:0]         found_position;
    logic [OL_POS_W-1:0]         entry_count;
    logic                        is_empty;
  } list_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [OL_IN_TDATA_W-1:0]  in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OL_OUT_TDATA_W-1:0] out_tdata;

  logic signed [OL_VAL_W-1:0] list_model[$];
  list_result_t               pending_results[$];
  logic signed [OL_VAL_W-1:0] value_pool[8];

  int  error_count;
  int  cycle_count;
  int  burst_left;
  bit  tx_free;
  bit  rx_free;
  int  rx_hold;
  int  rx_run;
  bit  rx_on;

  ordered_list_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic list_result_t apply_list_op(op_t op, logic signed [OL_VAL_W-1:0] value,
                                                 logic [OL_POS_W-1:0] position);
    list_result_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (op == OP_REMOVE || op == OP_FIND) begin
      for (int i = 0; i < list_model.size(); i++)
        if (hit < 0 && list_model[i] == value) hit = i;
    end
    case (op)
      OP_PUSH_FRONT: begin
        if (list_model.size() < OL_CAPACITY) begin
          list_model.push_front(value);
          r.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (list_model.size() < OL_CAPACITY) begin
          list_model.push_back(value);
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (list_model.size() > 0) begin
          void'(list_model.pop_front());
          r.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (list_model.size() > 0) begin
          void'(list_model.pop_back());
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          list_model.delete(hit);
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (position >= 1 && position <= list_model.size()) begin
          r.read_value = list_model[position - 1];
          r.ok         = 1'b1;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          r.found_position = OL_POS_W'(hit + 1);
          r.ok             = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = OL_POS_W'(list_model.size());
    r.is_empty    = (list_model.size() == 0);
    return r;
  endfunction

  task automatic send_item(op_t op, logic signed [OL_VAL_W-1:0] value,
                           logic [OL_POS_W-1:0] position);
    int gap;
    if (!tx_free && burst_left <= 0) begin
      in_tvalid  = 1'b0;
      gap        = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid = 1'b1;
    in_tdata  = {position, value, OL_ACT_W'(op)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, value, position));
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    out_tready = 1'b0;
    rx_on      = 1'b1;
    rx_run     = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else if (rx_free) begin
        out_tready = 1'b1;
      end else begin
        if (rx_run <= 0) begin
          rx_on  = !rx_on;
          rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        out_tready = rx_on;
        rx_run--;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, actual %0h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_tdata[0]));
        check_field("read_value", want.read_value, out_tdata[32:1]);
        check_field("found_position", 32'(want.found_position), 32'(out_tdata[37:33]));
        check_field("entry_count", 32'(want.entry_count), 32'(out_tdata[42:38]));
        check_field("is_empty", 32'(want.is_empty), 32'(out_tdata[43]));
      end
    end
  end

  function automatic logic signed [OL_VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_pool[$urandom_range(0, 7)];
    if (r < 8 && list_model.size() > 0)
      return list_model[$urandom_range(0, list_model.size() - 1)];
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_item(OP_POP_FRONT, 32'sd0, 5'd0);
    send_item(OP_POP_BACK, -32'sd1, 5'd31);
    send_item(OP_REMOVE, 32'sd0, 5'd1);
    send_item(OP_READ, 32'sd0, 5'd0);
    send_item(OP_NOP, 32'sh5a5a_a5a5, 5'd1);
    send_item(OP_FIND, 32'sd1, 5'd0);
  endtask

  task automatic test_fill_and_limits();
    send_item(OP_PUSH_BACK, 32'sh8000_0000, 5'd0);
    send_item(OP_PUSH_BACK, 32'sh7fff_ffff, 5'd0);
    send_item(OP_PUSH_FRONT, -32'sd1, 5'd0);
    send_item(OP_PUSH_FRONT, 32'sd0, 5'd0);
    send_item(OP_PUSH_BACK, 32'sd5, 5'd0);
    send_item(OP_PUSH_BACK, 32'sd5, 5'd0);
    for (int i = 0; i < OL_CAPACITY - 6; i++)
      send_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, 5'($urandom));
    send_item(OP_PUSH_FRONT, 32'sd9, 5'd0);
    send_item(OP_PUSH_BACK, 32'sd9, 5'd0);
    send_item(OP_READ, 32'sd0, 5'd16);
    send_item(OP_READ, 32'sd0, 5'd17);
    send_item(OP_FIND, 32'sh7fff_ffff, 5'd0);
    send_item(OP_REMOVE, 32'sd5, 5'd0);
  endtask

  task automatic test_random_traffic(int n_items, int grow_pct);
    op_t                        op;
    logic signed [OL_VAL_W-1:0] value;
    logic [OL_POS_W-1:0]        position;
    int                         r;
    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = 32'sh7fff_ffff;
    value_pool[3] = 32'sh8000_0000;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < grow_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25)      op = OP_POP_FRONT;
        else if (r < 45) op = OP_POP_BACK;
        else if (r < 65) op = OP_REMOVE;
        else if (r < 85) op = OP_READ;
        else if (r < 97) op = OP_FIND;
        else             op = OP_NOP;
      end
      value = pick_value();
      if ((op == OP_REMOVE || op == OP_FIND) && list_model.size() > 0
          && $urandom_range(0, 9) < 6)
        value = list_model[$urandom_range(0, list_model.size() - 1)];
      if ($urandom_range(0, 9) < 8)
        position = OL_POS_W'($urandom_range(0, list_model.size() + 1));
      else
        position = OL_POS_W'($urandom_range(0, 31));
      send_item(op, value, position);
    end
  endtask

  task automatic test_output_backpressure();
    tx_free = 1'b1;
    rx_hold = 100;
    test_random_traffic(40, 55);
    tx_free = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_free     = 1'b0;
    rx_free     = 1'b0;
    rx_hold     = 0;
    burst_left  = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_and_limits();
    test_random_traffic(250, 60);
    tx_free = 1'b1;
    rx_free = 1'b1;
    test_random_traffic(200, 75);
    tx_free = 1'b0;
    rx_free = 1'b0;
    test_random_traffic(200, 35);
    test_output_backpressure();
    test_random_traffic(200, 50);

    in_tvalid = 1'b0;
    rx_free   = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
